// ----- design/mbe_pkg.sv -----
package mbe_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_ITER   = 2'd0;
  localparam logic [1:0] REG_ESC_LIMIT  = 2'd1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_ITER_W = 13;
  localparam int ESC_W      = 31;
  localparam int COORD_W    = 32;
  localparam int LEVEL_W    = 8;

  localparam logic [13:0] RESET_MAX_ITER  = 14'd256;
  localparam logic [30:0] RESET_ESC_LIMIT = 31'd1677721600;  // 100.0 in Q7.24

  localparam logic [7:0] RED_MUL  = 8'd6;
  localparam logic [7:0] BLUE_MUL = 8'd10;

  // point payload moving round the ring
  typedef struct packed {
    logic                      done;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] cr;
    logic signed [COORD_W-1:0] ci;
  } pt_t;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[COORD_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/mbe_cell.sv -----
// One iteration z = z*z + c over two register stages.
module mbe_cell #(
  parameter int FRAC_BITS = 24,
  parameter int CNT_W     = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  mbe_pkg::pt_t      pt_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [CNT_W-1:0]  limit_i,
  input  logic [63:0]       bound_i,
  output logic              valid_o,
  output mbe_pkg::pt_t      pt_o,
  output logic [CNT_W-1:0]  count_o
);

  // stage 1: squares and cross product
  logic                     v1_q;
  logic                     done1_q;
  logic signed [31:0]       cr1_q, ci1_q;
  logic [CNT_W-1:0]         count1_q;
  logic signed [63:0]       xx_q, yy_q, xy_q;

  // stage 2
  logic                     v2_q;
  mbe_pkg::pt_t             pt2_q;
  logic [CNT_W-1:0]         count2_q;

  logic [63:0]              r2;
  logic                     stop;
  logic signed [63:0]       diff, sx, sy;
  logic signed [65:0]       nx, ny;
  mbe_pkg::pt_t             pt2_d;
  logic [CNT_W-1:0]         count2_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    done1_q  <= pt_i.done;
    cr1_q    <= pt_i.cr;
    ci1_q    <= pt_i.ci;
    count1_q <= count_i;
    xx_q     <= pt_i.x * pt_i.x;
    yy_q     <= pt_i.y * pt_i.y;
    xy_q     <= pt_i.x * pt_i.y;
    pt2_q    <= pt2_d;
    count2_q <= count2_d;
  end

  always_comb begin
    r2   = $unsigned(xx_q) + $unsigned(yy_q);
    stop = done1_q || (count1_q == limit_i) || (r2 > bound_i);
    diff = xx_q - yy_q;
    sx   = diff >>> FRAC_BITS;
    sy   = xy_q >>> (FRAC_BITS - 1);  // floor(2xy / 2^F)
    nx   = 66'(sx) + 66'(cr1_q);
    ny   = 66'(sy) + 66'(ci1_q);
    pt2_d.done = stop;
    pt2_d.x    = mbe_pkg::sat32(nx);
    pt2_d.y    = mbe_pkg::sat32(ny);
    pt2_d.cr   = cr1_q;
    pt2_d.ci   = ci1_q;
    count2_d   = stop ? count1_q : count1_q + CNT_W'(1);
  end

  assign valid_o = v2_q;
  assign pt_o    = pt2_q;
  assign count_o = count2_q;

endmodule

// ----- design/mandelbrot_escape_counter_unit.sv -----
// Each iteration passes the two register stages of one cell; a point leaves
//   the ring only at the last cell, so its iterations round up to whole ring laps.
// One point at a time: tready returns once the result is captured; a stalled
//   result sends the point round further laps of the ring.
// Reset: async, active low; clears ring, busy and result valid; limits 256, 100.0.
module mandelbrot_escape_counter_unit #(
  parameter int FRAC_BITS = 24,
  parameter int COUNT_MAX = 4096,
  parameter int CELLS     = 4,
  localparam int CNT_W    = $clog2(COUNT_MAX + 1),
  localparam int OUT_W    = ((CNT_W + 16 + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [63:0]                    s_axis_tdata,  // c_real[31:0], c_imag[63:32]
  // result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_W-1:0]               m_axis_tdata,  // iter_count, red, blue, zero pad
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LIM_W = (CNT_W > mbe_pkg::MAX_ITER_W) ? CNT_W : mbe_pkg::MAX_ITER_W;
  localparam int PAD_W = OUT_W - CNT_W - 16;

  // config registers
  logic [mbe_pkg::MAX_ITER_W-1:0] max_iter_q;
  logic [mbe_pkg::ESC_W-1:0]      esc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= mbe_pkg::RESET_MAX_ITER[mbe_pkg::MAX_ITER_W-1:0];
      esc_q      <= mbe_pkg::RESET_ESC_LIMIT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mbe_pkg::REG_MAX_ITER:  max_iter_q <= cfg_data_i[mbe_pkg::MAX_ITER_W-1:0];
        mbe_pkg::REG_ESC_LIMIT: esc_q      <= cfg_data_i[mbe_pkg::ESC_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // effective limit, capped at COUNT_MAX
  logic [LIM_W-1:0] mi_ext;
  logic [LIM_W-1:0] cap_ext;
  logic [CNT_W-1:0] limit;
  logic [63:0]      bound;

  assign mi_ext  = LIM_W'(max_iter_q);
  assign cap_ext = LIM_W'(COUNT_MAX);
  assign limit   = (mi_ext > cap_ext) ? CNT_W'(cap_ext) : CNT_W'(mi_ext);
  assign bound   = {{(64 - mbe_pkg::ESC_W - FRAC_BITS){1'b0}}, esc_q, {FRAC_BITS{1'b0}}};

  // ring of iteration cells
  logic               cv_in  [CELLS];
  mbe_pkg::pt_t       cp_in  [CELLS];
  logic [CNT_W-1:0]   cc_in  [CELLS];
  logic               cv_out [CELLS];
  mbe_pkg::pt_t       cp_out [CELLS];
  logic [CNT_W-1:0]   cc_out [CELLS];

  logic         busy_q;
  logic         accept;
  logic         exit_done;
  logic         capture;
  mbe_pkg::pt_t load_pt;

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && !busy_q;
  assign exit_done     = cv_out[CELLS-1] && cp_out[CELLS-1].done;
  assign capture       = exit_done && (!m_axis_tvalid || m_axis_tready);

  // z starts at c
  always_comb begin
    load_pt.done = 1'b0;
    load_pt.x    = s_axis_tdata[31:0];
    load_pt.y    = s_axis_tdata[63:32];
    load_pt.cr   = s_axis_tdata[31:0];
    load_pt.ci   = s_axis_tdata[63:32];
  end

  // cell 0 takes a fresh point or the item coming back round
  assign cv_in[0] = accept || (cv_out[CELLS-1] && !capture);
  assign cp_in[0] = accept ? load_pt : cp_out[CELLS-1];
  assign cc_in[0] = accept ? '0 : cc_out[CELLS-1];

  for (genvar k = 1; k < CELLS; k++) begin : g_link
    assign cv_in[k] = cv_out[k-1];
    assign cp_in[k] = cp_out[k-1];
    assign cc_in[k] = cc_out[k-1];
  end

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    mbe_cell #(
      .FRAC_BITS (FRAC_BITS),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv_in[k]),
      .pt_i    (cp_in[k]),
      .count_i (cc_in[k]),
      .limit_i (limit),
      .bound_i (bound),
      .valid_o (cv_out[k]),
      .pt_o    (cp_out[k]),
      .count_o (cc_out[k])
    );
  end

  // one point in flight at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (capture) begin
      busy_q <= 1'b0;
    end
  end

  // output register: frees the ring while the result waits
  logic                    out_valid_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [7:0]              red_q, blue_q;
  logic [CNT_W-1:0]        fin_cnt;

  assign fin_cnt = cc_out[CELLS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (capture) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      cnt_q  <= fin_cnt;
      red_q  <= 8'(fin_cnt[7:0] * mbe_pkg::RED_MUL);
      blue_q <= 8'(fin_cnt[7:0] * mbe_pkg::BLUE_MUL);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, blue_q, red_q, cnt_q};

endmodule

// ----- design/mbe_checker.sv -----
module mbe_prop_checker #(
  parameter int CNT_W = 13,
  parameter int OUT_W = 32
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // colour bytes follow the count
  a_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[CNT_W+7:CNT_W] == 8'(m_axis_tdata[7:0] * 8'd6))
    else $error("red level does not match count");

  a_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[CNT_W+15:CNT_W+8] == 8'(m_axis_tdata[7:0] * 8'd10))
    else $error("blue level does not match count");

  // one point at a time: no second item straight after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a point is in flight");

endmodule

bind mandelbrot_escape_counter_unit mbe_prop_checker #(
  .CNT_W (CNT_W),
  .OUT_W (OUT_W)
) u_mbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
